@@ rtl/gsa_pkg.sv @@
// gsa_pkg: shared types and constants of the growable slot allocator
// holds field widths, status, operation and state codes, register indexes and defaults
// no dependencies
package gsa_pkg;

  localparam int MAX_CAPACITY_DEF    = 1024;
  localparam int MAX_BLOCK_COUNT_DEF = 8;

  localparam int CNT_W  = 11;  // count, capacity, tail
  localparam int BLKF_W = 3;   // block field on the ports
  localparam int IDXF_W = 10;  // slot index field on the ports
  localparam int MAXB_W = 4;
  localparam int INC_W  = 9;
  localparam int OFF_W  = 18;

  localparam logic [CNT_W-1:0]  CAPACITY_RST  = 11'd1024;
  localparam logic [MAXB_W-1:0] MAX_BLOCKS_RST = 4'd8;
  localparam logic [INC_W-1:0]  INCREMENT_RST = 9'd32;
  localparam logic [INC_W-1:0]  INCREMENT_MAX = 9'd256;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STAT_ALLOC     = 3'd0,
    STAT_FREED     = 3'd1,
    STAT_ZERO      = 3'd2,
    STAT_TOO_LARGE = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_BAD_BLOCK = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_CAPACITY   = 2'd0,
    REG_MAX_BLOCKS = 2'd1,
    REG_INCREMENT  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_POP,
    ST_MUL,
    ST_FREE_LD,
    ST_PUSH,
    ST_OUT
  } state_t;

endpackage

@@ rtl/growable_slot_allocator.sv @@
// growable_slot_allocator: bump allocator with a per-block free stack
// block metadata (tail, stack depth) and the free stacks live in two synchronous memories
// depends on gsa_pkg
// steps to the result: zero count, bad block, too large: straight to output;
//   allocate: block probes, then stack pop (one slot), multiply, output; all full: output;
//   free: metadata load, then one slot per cycle, pushed while within capacity, then output
// one transaction at a time; the next is accepted as soon as the result is in the
//   output register; a result waiting on m_tready stalls the next result and the input
// reset: registers to defaults, one block in use, metadata reads as zero until written;
//   stack memory has no reset and needs no clearing pass
module growable_slot_allocator
  import gsa_pkg::*;
#(
  parameter int MAX_CAPACITY    = MAX_CAPACITY_DEF,
  parameter int MAX_BLOCK_COUNT = MAX_BLOCK_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input transactions
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // count[10:0], which_block[13:11], first_index[23:14]
  input  logic        s_tuser,   // op
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // block_index[2:0], slot_index[12:3], granted_count[23:13],
                                 // byte_offset[41:24], zero fill
  output logic [2:0]  m_tuser,   // status
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CAP_LIM = (MAX_CAPACITY < 2047) ? MAX_CAPACITY : 2047;
  localparam int IDX_W   = $clog2(CAP_LIM);
  localparam int SA_W    = $clog2(MAX_CAPACITY);
  localparam int DEP_W   = $clog2(MAX_CAPACITY + 1);
  localparam int BLK_W   = (MAX_BLOCK_COUNT > 1) ? $clog2(MAX_BLOCK_COUNT) : 1;
  localparam int BIU_W   = $clog2(MAX_BLOCK_COUNT + 1);
  localparam int META_W  = CNT_W + DEP_W;
  localparam int STK_N   = MAX_BLOCK_COUNT * (2 ** SA_W);
  localparam int PROD_W  = IDX_W + INC_W;

  // configuration registers
  logic [CNT_W-1:0]  cfg_capacity;
  logic [MAXB_W-1:0] cfg_max_blocks;
  logic [INC_W-1:0]  cfg_increment;

  logic              cfg_we;
  logic [CNT_W-1:0]  cap;
  logic [BIU_W-1:0]  emax;
  logic [INC_W-1:0]  inc;

  // input fields
  logic [CNT_W-1:0]  in_count;
  logic [BLKF_W-1:0] in_block;
  logic [IDXF_W-1:0] in_first;
  logic              in_accept;

  // control and working registers
  state_t            state, state_next;
  logic [BIU_W-1:0]  biu;
  logic [BLK_W-1:0]  b;
  logic              grown;
  logic [CNT_W-1:0]  cnt_r;
  logic [BLKF_W-1:0] wb_r;
  logic [IDXF_W-1:0] fi_r;
  logic [IDX_W-1:0]  base;
  logic [CNT_W-1:0]  wtail;
  logic [DEP_W-1:0]  wdepth;
  logic [CNT_W:0]    idx;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  pushed;

  // pending result
  status_t           res_status;
  logic [BLKF_W-1:0] res_blk;
  logic [IDXF_W-1:0] res_slot;
  logic [CNT_W-1:0]  res_cnt;
  logic [OFF_W-1:0]  res_off;

  // metadata memory
  logic [META_W-1:0]          meta_mem [0:MAX_BLOCK_COUNT-1];
  logic [MAX_BLOCK_COUNT-1:0] meta_valid;
  logic [META_W-1:0]          meta_q;
  logic                       meta_vq;
  logic [BLK_W-1:0]           meta_raddr;
  logic                       meta_we;
  logic [META_W-1:0]          meta_wdata;

  // free stack memory
  logic [IDX_W-1:0]      stack_mem [0:STK_N-1];
  logic [IDX_W-1:0]      stack_q;
  logic [BLK_W+SA_W-1:0] stack_raddr;
  logic [BLK_W+SA_W-1:0] stack_waddr;
  logic                  stack_we;

  // decoded metadata of the block just read
  logic [CNT_W-1:0]  cur_tail;
  logic [DEP_W-1:0]  cur_depth;
  logic [DEP_W-1:0]  dep_dec;
  logic              can_pop;
  logic              can_bump;
  logic [BIU_W-1:0]  b_inc;
  logic              more;
  logic              grow;
  logic              do_push;
  logic [DEP_W-1:0]  depth_after;
  logic [PROD_W-1:0] prod;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready;
  assign in_count = s_tdata[10:0];
  assign in_block = s_tdata[13:11];
  assign in_first = s_tdata[23:14];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // register port
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_capacity   <= CAPACITY_RST;
      cfg_max_blocks <= MAX_BLOCKS_RST;
      cfg_increment  <= INCREMENT_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_CAPACITY:   cfg_capacity   <= pwdata[CNT_W-1:0];
        REG_MAX_BLOCKS: cfg_max_blocks <= pwdata[MAXB_W-1:0];
        REG_INCREMENT:  cfg_increment  <= pwdata[INC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CAPACITY:   prdata = 32'(cfg_capacity);
      REG_MAX_BLOCKS: prdata = 32'(cfg_max_blocks);
      REG_INCREMENT:  prdata = 32'(cfg_increment);
      default:        prdata = '0;
    endcase
  end

  // effective settings
  always_comb begin
    if (cfg_capacity == '0) cap = CNT_W'(1);
    else if (int'(cfg_capacity) > MAX_CAPACITY) cap = CNT_W'(MAX_CAPACITY);
    else cap = cfg_capacity;

    if (cfg_max_blocks == '0) emax = BIU_W'(1);
    else if (int'(cfg_max_blocks) > MAX_BLOCK_COUNT) emax = BIU_W'(MAX_BLOCK_COUNT);
    else emax = BIU_W'(cfg_max_blocks);

    inc = (cfg_increment > INCREMENT_MAX) ? INCREMENT_MAX : cfg_increment;
  end

  // memories
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[b] <= meta_wdata;
    meta_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_valid <= MAX_BLOCK_COUNT'(1'b0);
      meta_vq    <= 1'b0;
    end else begin
      if (meta_we) meta_valid[b] <= 1'b1;
      meta_vq <= meta_valid[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= IDX_W'(idx);
    stack_q <= stack_mem[stack_raddr];
  end

  // a block never written reads as empty
  assign cur_tail    = meta_vq ? meta_q[META_W-1 -: CNT_W] : '0;
  assign cur_depth   = meta_vq ? meta_q[DEP_W-1:0] : '0;
  assign dep_dec     = cur_depth - DEP_W'(1);
  assign can_pop     = (cnt_r == CNT_W'(1)) && (cur_depth != '0);
  assign can_bump    = ({1'b0, cur_tail} + {1'b0, cnt_r}) <= {1'b0, cap};
  assign b_inc       = BIU_W'(b) + BIU_W'(1);
  assign more        = !grown && (b_inc < biu);
  assign grow        = !grown && !more && (biu < emax);
  assign do_push     = (idx < {1'b0, cap}) && (wdepth < DEP_W'(MAX_CAPACITY));
  assign depth_after = wdepth + DEP_W'(do_push);
  assign stack_waddr = {b, wdepth[SA_W-1:0]};
  assign prod        = PROD_W'(base) * PROD_W'(inc);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    meta_raddr  = '0;
    meta_we     = 1'b0;
    meta_wdata  = {cur_tail, cur_depth};
    stack_raddr = {b, dep_dec[SA_W-1:0]};
    stack_we    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (op_t'(s_tuser) == OP_FREE) meta_raddr = BLK_W'(in_block);
        if (in_accept) begin
          if (in_count == '0) begin
            state_next = ST_OUT;
          end else if (op_t'(s_tuser) == OP_FREE) begin
            state_next = (int'(in_block) >= int'(biu)) ? ST_OUT : ST_FREE_LD;
          end else begin
            state_next = (in_count > cap) ? ST_OUT : ST_ALLOC;
          end
        end
      end
      ST_ALLOC: begin
        meta_raddr = BLK_W'(b_inc);
        if (can_pop) begin
          meta_we    = 1'b1;
          meta_wdata = {cur_tail, dep_dec};
          state_next = ST_POP;
        end else if (can_bump) begin
          meta_we    = 1'b1;
          meta_wdata = {cur_tail + cnt_r, cur_depth};
          state_next = ST_MUL;
        end else if (!(more || grow)) begin
          state_next = ST_OUT;
        end
      end
      ST_POP:     state_next = ST_MUL;
      ST_MUL:     state_next = ST_OUT;
      ST_FREE_LD: state_next = ST_PUSH;
      ST_PUSH: begin
        stack_we = do_push;
        if (rem == CNT_W'(1)) begin
          meta_we    = 1'b1;
          meta_wdata = {wtail, depth_after};
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // block count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      biu      <= BIU_W'(1);
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_ALLOC && !can_pop && !can_bump && grow) biu <= biu + BIU_W'(1);
      if (state == ST_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cnt_r      <= in_count;
        wb_r       <= in_block;
        fi_r       <= in_first;
        b          <= (op_t'(s_tuser) == OP_FREE) ? BLK_W'(in_block) : '0;
        grown      <= 1'b0;
        res_blk    <= '0;
        res_slot   <= '0;
        res_cnt    <= '0;
        res_off    <= '0;
        if (in_count == '0) res_status <= STAT_ZERO;
        else if (op_t'(s_tuser) == OP_FREE) res_status <= STAT_BAD_BLOCK;
        else res_status <= STAT_TOO_LARGE;
      end
      ST_ALLOC: begin
        if (can_pop) begin
          grown <= grown;
        end else if (can_bump) begin
          base <= IDX_W'(cur_tail);
        end else if (more || grow) begin
          b <= BLK_W'(b_inc);
          if (grow) grown <= 1'b1;
        end else begin
          res_status <= STAT_FULL;
        end
      end
      ST_POP: base <= stack_q;
      ST_MUL: begin
        res_status <= STAT_ALLOC;
        res_blk    <= BLKF_W'(b);
        res_slot   <= IDXF_W'(base);
        res_cnt    <= cnt_r;
        res_off    <= OFF_W'(prod);
      end
      ST_FREE_LD: begin
        wtail  <= cur_tail;
        wdepth <= cur_depth;
        idx    <= (CNT_W + 1)'(fi_r);
        rem    <= cnt_r;
        pushed <= '0;
      end
      ST_PUSH: begin
        wdepth <= depth_after;
        pushed <= pushed + CNT_W'(do_push);
        idx    <= idx + (CNT_W + 1)'(1);
        rem    <= rem - CNT_W'(1);
        if (rem == CNT_W'(1)) begin
          res_status <= STAT_FREED;
          res_blk    <= wb_r;
          res_slot   <= fi_r;
          res_cnt    <= pushed + CNT_W'(do_push);
          res_off    <= '0;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tuser <= res_status;
          m_tdata <= {6'b0, res_off, res_cnt, res_slot, res_blk};
        end
      end
      default: ;
    endcase
  end

  // checks
  a_biu_range: assert property (@(posedge clk) disable iff (rst)
    (biu != '0) && (int'(biu) <= MAX_BLOCK_COUNT))
    else $error("blocks in use out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_tready)
    else $error("transaction accepted while another is in progress");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STAT_ALLOC) |-> (m_tdata[23:13] != '0))
    else $error("allocation granted with zero count");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) |-> (int'(wdepth) <= MAX_CAPACITY))
    else $error("free stack depth beyond capacity");

endmodule
